>>> rtl/i2f_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2f_pkg
// types and codes shared by the integer to float32 converter
// ----------------------------------------------------------------------------
package i2f_pkg;

    typedef enum logic [3:0] {
        ET_S8      = 4'd0,
        ET_U8      = 4'd1,
        ET_S16     = 4'd2,
        ET_U16     = 4'd3,
        ET_S32     = 4'd4,
        ET_U32     = 4'd5,
        ET_F32     = 4'd6,
        ET_CPX_S16 = 4'd7,
        ET_CPX_F32 = 4'd8
    } t_elem_type;

    localparam logic [3:0] ELEM_TYPE_RESET = 4'd6;

    typedef struct packed {
        logic [31:0] raw_bits;
        logic        last_element;
    } t_in_item;

    typedef struct packed {
        logic [31:0] float_bits;
        logic        type_error;
        logic        last_result;
    } t_out_item;

endpackage
`default_nettype wire

>>> rtl/integer_to_float32_converter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_float32_converter_unit
// converts one raw element per transaction to IEEE-754 single precision
// ----------------------------------------------------------------------------
// Accepts one element per clock while the output is not stalled and delivers
// its float32 encoding through a four-stage pipeline (decode and magnitude,
// leading-one search, normalising shift, rounding and packing); stalls hold
// every stage. The element type register is written through its own channel;
// the user must write it only while idle, which the block does not enforce;
// complex and undefined types give type_error with a zero result.
module integer_to_float32_converter_unit
    import i2f_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [3:0] i_cfg_data,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data
);

    logic [3:0] r_type;
    logic       adv;
    logic [3:0] r_v;

    // stage 1: sign and magnitude
    logic        r_s1_neg, r_s1_pass, r_s1_err, r_s1_last;
    logic [31:0] r_s1_mag;
    // stage 2: leading one position
    logic        r_s2_neg, r_s2_pass, r_s2_err, r_s2_last, r_s2_zero;
    logic [31:0] r_s2_mag;
    logic [4:0]  r_s2_p;
    // stage 3: normalised
    logic        r_s3_neg, r_s3_pass, r_s3_err, r_s3_last, r_s3_zero;
    logic [31:0] r_s3_norm;
    logic [31:0] r_s3_raw;
    logic [4:0]  r_s3_p;

    logic [31:0] n_s1_mag;
    logic        n_s1_neg, n_s1_pass, n_s1_err;
    logic [4:0]  n_s2_p;
    logic [23:0] n_s4_frac;
    logic        n_s4_up;
    logic [31:0] n_s4_bits;

    assign o_cfg_ready = 1'b1;
    assign adv         = !o_valid || i_ready;
    assign o_ready     = adv;
    assign o_valid     = r_v[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type <= ELEM_TYPE_RESET;
            r_v    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_type <= i_cfg_data;
            end
            if (adv) begin
                r_v <= {r_v[2:0], i_valid};
            end
        end
    end

    always_comb begin
        n_s1_mag  = '0;
        n_s1_neg  = 1'b0;
        n_s1_pass = 1'b0;
        n_s1_err  = 1'b0;
        case (r_type)
            ET_S8: begin
                n_s1_neg = i_data.raw_bits[7];
                n_s1_mag = n_s1_neg ? 32'(8'(-i_data.raw_bits[7:0]))
                                    : 32'(i_data.raw_bits[7:0]);
            end
            ET_U8:  n_s1_mag = 32'(i_data.raw_bits[7:0]);
            ET_S16: begin
                n_s1_neg = i_data.raw_bits[15];
                n_s1_mag = n_s1_neg ? 32'(16'(-i_data.raw_bits[15:0]))
                                    : 32'(i_data.raw_bits[15:0]);
            end
            ET_U16: n_s1_mag = 32'(i_data.raw_bits[15:0]);
            ET_S32: begin
                n_s1_neg = i_data.raw_bits[31];
                n_s1_mag = n_s1_neg ? -i_data.raw_bits : i_data.raw_bits;
            end
            ET_U32: n_s1_mag = i_data.raw_bits;
            ET_F32: begin
                n_s1_pass = 1'b1;
                n_s1_mag  = i_data.raw_bits;
            end
            default: n_s1_err = 1'b1;
        endcase
    end

    always_comb begin
        n_s2_p = '0;
        for (int i = 0; i < 32; i++) begin
            if (r_s1_mag[i]) begin
                n_s2_p = 5'(i);
            end
        end
    end

    // round to nearest even on the 8 bits below the 24-bit significand
    always_comb begin
        n_s4_up   = r_s3_norm[7] && (r_s3_norm[8] || (r_s3_norm[6:0] != '0));
        n_s4_frac = r_s3_norm[31:8] + 24'(n_s4_up);
        n_s4_bits = ({r_s3_neg, 31'd0} + ({27'd0, r_s3_p} + 32'd126 << 23))
                    + ((n_s4_frac == '0) ? 32'h0100_0000 : 32'(n_s4_frac));
        if (r_s3_pass) begin
            n_s4_bits = r_s3_raw;
        end else if (r_s3_err || r_s3_zero) begin
            n_s4_bits = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_neg  <= n_s1_neg;
            r_s1_pass <= n_s1_pass;
            r_s1_err  <= n_s1_err;
            r_s1_last <= i_data.last_element;
            r_s1_mag  <= n_s1_mag;

            r_s2_neg  <= r_s1_neg;
            r_s2_pass <= r_s1_pass;
            r_s2_err  <= r_s1_err;
            r_s2_last <= r_s1_last;
            r_s2_zero <= (r_s1_mag == '0);
            r_s2_mag  <= r_s1_mag;
            r_s2_p    <= n_s2_p;

            r_s3_neg  <= r_s2_neg;
            r_s3_pass <= r_s2_pass;
            r_s3_err  <= r_s2_err;
            r_s3_last <= r_s2_last;
            r_s3_zero <= r_s2_zero;
            r_s3_raw  <= r_s2_mag;
            r_s3_norm <= r_s2_mag << (5'd31 - r_s2_p);
            r_s3_p    <= r_s2_p;

            o_data.float_bits  <= n_s4_bits;
            o_data.type_error  <= r_s3_err;
            o_data.last_result <= r_s3_last;
        end
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.type_error |-> o_data.float_bits == '0)
        else $error("error result not zero");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |-> ##4 (r_v != '0) || $past(!i_ready))
        else $error("accepted transaction lost");

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the integer to float32 converter
// clocked driver fed from a queue, clocked monitor against a predictor,
// element type written between phases once drained, every code covered
// ----------------------------------------------------------------------------
module tb_top;
    import i2f_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [3:0] i_cfg_data = '0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_data;

    integer_to_float32_converter_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #1 i_clk = ~i_clk;

    t_in_item  pending_items[$];
    t_out_item expected_floats[$];
    logic [3:0] elem_type = ELEM_TYPE_RESET;
    int        failures = 0;
    bit        quiet = 1'b0;
    int        hold_off = 0;
    int        send_gap = 0;
    int        recv_gap = 0;

    function automatic logic [31:0] magnitude_to_float(logic neg, logic [31:0] m);
        int          p;
        int          sh;
        logic [31:0] frac;
        logic [31:0] rem;
        logic [31:0] half;
        p = 0;
        if (m == 0) return 32'd0;
        for (int i = 0; i < 32; i++) if (m[i]) p = i;
        if (p <= 23) begin
            frac = m << (23 - p);
        end else begin
            sh = p - 23;
            rem = m & ((32'd1 << sh) - 1);
            half = 32'd1 << (sh - 1);
            frac = m >> sh;
            if (rem > half || (rem == half && frac[0])) frac = frac + 1;
        end
        return ({neg, 31'd0}) + ((32'd126 + p) << 23) + frac;
    endfunction

    function automatic t_out_item convert_element(t_in_item it, logic [3:0] et);
        t_out_item r;
        logic [31:0] x;
        x = it.raw_bits;
        r.type_error = 1'b0;
        r.last_result = it.last_element;
        case (et)
            ET_S8:  r.float_bits = magnitude_to_float(x[7],
                        x[7] ? {24'd0, -x[7:0]} : {24'd0, x[7:0]});
            ET_U8:  r.float_bits = magnitude_to_float(1'b0, {24'd0, x[7:0]});
            ET_S16: r.float_bits = magnitude_to_float(x[15],
                        x[15] ? {16'd0, -x[15:0]} : {16'd0, x[15:0]});
            ET_U16: r.float_bits = magnitude_to_float(1'b0, {16'd0, x[15:0]});
            ET_S32: r.float_bits = magnitude_to_float(x[31], x[31] ? -x : x);
            ET_U32: r.float_bits = magnitude_to_float(1'b0, x);
            ET_F32: r.float_bits = x;
            default: begin
                r.float_bits = '0;
                r.type_error = 1'b1;
            end
        endcase
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            expected_floats.push_back(convert_element(i_data, elem_type));
        end
        if (!i_valid || o_ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_data <= pending_items.pop_front();
                i_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 7);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item e;
        if (o_valid && i_ready) begin
            if (expected_floats.size() == 0) begin
                $error("unexpected transaction float_bits %h", o_data.float_bits);
                failures++;
            end else begin
                e = expected_floats.pop_front();
                if (e.float_bits !== o_data.float_bits) begin
                    $error("float_bits expected %h actual %h", e.float_bits, o_data.float_bits);
                    failures++;
                end
                if (e.type_error !== o_data.type_error) begin
                    $error("type_error expected %b actual %b", e.type_error, o_data.type_error);
                    failures++;
                end
                if (e.last_result !== o_data.last_result) begin
                    $error("last_result expected %b actual %b",
                           e.last_result, o_data.last_result);
                    failures++;
                end
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 7);
        end
    end

    function automatic t_in_item random_element();
        t_in_item it;
        it.raw_bits = $urandom();
        case ($urandom_range(0, 5))
            0: it.raw_bits = it.raw_bits & 32'hff;
            1: it.raw_bits = it.raw_bits >> $urandom_range(0, 31);
            2: it.raw_bits = ~(it.raw_bits >> $urandom_range(0, 31));
            default: ;
        endcase
        it.last_element = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic push_element(logic [31:0] v, logic last);
        t_in_item it;
        it.raw_bits = v;
        it.last_element = last;
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_floats.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_type(logic [3:0] et);
        @(posedge i_clk);
        i_cfg_data <= et;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        elem_type = et;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] corner[9];
        corner = '{32'h0, 32'h1, 32'h7f, 32'h80, 32'hff, 32'h7fff, 32'h8000,
                   32'h7fffffff, 32'h80000000};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed part under the reset type
        foreach (corner[i]) push_element(corner[i], i[0]);
        drain();
        for (int t = 0; t < 16; t++) begin
            write_type(t[3:0]);
            foreach (corner[i]) push_element(corner[i], i[0]);
            push_element(32'hffffffff, 1'b1);
            push_element(32'h01000001, 1'b0);
            push_element(32'h01000003, 1'b0);
            push_element(32'hfffffe80, 1'b1);
            if (t == 4) hold_off = 60;
            for (int k = 0; k < (t < 9 ? 125 : 30); k++)
                pending_items.push_back(random_element());
            if (t == 15) quiet = 1'b1;
            drain();
        end
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule
